// File: hw/rtl/tfsc_pkg.sv
package tfsc_pkg;

	// default timer input clock
	localparam int CLOCK_HZ_DEF = 8000000;

	// request thresholds and divisor limit
	localparam int SLOW_LIMIT = 15;
	localparam int MAX_DIV    = 256;
	localparam int NUM_PRESC  = 7;

	// field widths
	localparam int CS_W  = 3;
	localparam int CV_W  = 8;
	localparam int AF_W  = 22;
	localparam int REQ_W = 32;
	localparam int QW    = 9;   // divisor up to 256
	localparam int KW    = 3;   // prescaler index

	// clock-select codes
	localparam logic [CS_W-1:0] CS_STOP    = 3'd0;
	localparam logic [CS_W-1:0] CS_FASTEST = 3'd1;
	localparam logic [CS_W-1:0] CS_SLOWEST = 3'd7;

	// log2 of prescaler 1,8,32,64,128,256,1024 by index
	function automatic logic [3:0] presc_shift(input logic [KW-1:0] k);
		logic [3:0] s;
		case (k)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd3;
			3'd2:    s = 4'd5;
			3'd3:    s = 4'd6;
			3'd4:    s = 4'd7;
			3'd5:    s = 4'd8;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/timer_frequency_setup_calculator.sv
// Stop, slowest and fastest requests are answered from idle, in the cycle after start;
// otherwise a prescaler search, then two serial divisions of width RW (RW = 22 at
// 8 MHz): first the divisor, then the actual frequency.
// One request at a time: busy is high from the search until the result strobe, done.
// Asynchronous active-low reset returns the controller and divider to idle.
// The result strobe shows for one cycle; the receiver cannot stall.
module timer_frequency_setup_calculator
	import tfsc_pkg::*;
#(
	parameter int CLOCK_HZ = CLOCK_HZ_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REQ_W-1:0] requested_freq,
	output logic             busy,
	output logic             done,
	output logic [CS_W-1:0]  clock_select,
	output logic [CV_W-1:0]  compare_value,
	output logic             compare_write,
	output logic [AF_W-1:0]  actual_freq
);

	localparam int TOP_HZ = CLOCK_HZ / 2;
	localparam int RW     = $clog2(TOP_HZ + 1);
	localparam logic [RW-1:0] TOP_C  = RW'(TOP_HZ);
	localparam logic [AF_W-1:0] SLOW_AF = AF_W'(TOP_HZ / 1024 / MAX_DIV);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIVQ,
		ST_DIVF
	} state_t;

	state_t          state_q;
	logic [KW-1:0]   k_q;
	logic [RW-1:0]   req_q;
	logic [RW-1:0]   rate_q;
	logic            dstart_q;
	logic [RW-1:0]   ddvd_q;
	logic [RW-1:0]   ddvs_q;
	logic            done_q;
	logic [CS_W-1:0] cs_q;
	logic [CV_W-1:0] cv_q;
	logic            cw_q;
	logic [AF_W-1:0] af_q;

	logic            div_done;
	logic [RW-1:0]   div_quo;
	logic [RW-1:0]   rate_k;
	logic [RW+8:0]   lim;
	logic [QW-1:0]   q_raw;
	logic [QW-1:0]   q_fix;

	// prescaled rate for this try, and 257 * request
	assign rate_k = TOP_C >> presc_shift(k_q);
	assign lim    = {1'b0, req_q, 8'b0} + (RW+9)'(req_q);

	// divisor from first division, zero taken as one
	assign q_raw = div_quo[QW-1:0];
	assign q_fix = (q_raw == '0) ? QW'(1) : q_raw;

	tfsc_div #(
		.W(RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart_q),
		.dividend (ddvd_q),
		.divisor  (ddvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// controller and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			req_q    <= '0;
			rate_q   <= '0;
			ddvd_q   <= '0;
			ddvs_q   <= '0;
			dstart_q <= 1'b0;
			done_q   <= 1'b0;
			cs_q     <= CS_STOP;
			cv_q     <= '0;
			cw_q     <= 1'b0;
			af_q     <= '0;
		end else begin
			done_q   <= 1'b0;
			dstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (requested_freq == '0) begin
							cs_q   <= CS_STOP;
							cv_q   <= '0;
							cw_q   <= 1'b0;
							af_q   <= '0;
							done_q <= 1'b1;
						end else if (requested_freq <= REQ_W'(SLOW_LIMIT)) begin
							cs_q   <= CS_SLOWEST;
							cv_q   <= CV_W'(MAX_DIV - 1);
							cw_q   <= 1'b1;
							af_q   <= SLOW_AF;
							done_q <= 1'b1;
						end else if (requested_freq >= REQ_W'(TOP_HZ)) begin
							cs_q   <= CS_FASTEST;
							cv_q   <= '0;
							cw_q   <= 1'b1;
							af_q   <= AF_W'(TOP_HZ);
							done_q <= 1'b1;
						end else begin
							req_q   <= requested_freq[RW-1:0];
							k_q     <= '0;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					// quotient <= 256 exactly when rate < 257 * request
					if ({9'b0, rate_k} < lim) begin
						rate_q   <= rate_k;
						ddvd_q   <= rate_k;
						ddvs_q   <= req_q;
						dstart_q <= 1'b1;
						state_q  <= ST_DIVQ;
					end else if (k_q == KW'(NUM_PRESC - 1)) begin
						cs_q    <= CS_SLOWEST;
						cv_q    <= CV_W'(MAX_DIV - 1);
						cw_q    <= 1'b1;
						af_q    <= SLOW_AF;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DIVQ: begin
					if (div_done) begin
						cs_q     <= CS_W'(k_q) + CS_W'(1);
						cv_q     <= CV_W'(q_fix - QW'(1));
						cw_q     <= 1'b1;
						ddvd_q   <= rate_q;
						ddvs_q   <= RW'(q_fix);
						dstart_q <= 1'b1;
						state_q  <= ST_DIVF;
					end
				end
				ST_DIVF: begin
					if (div_done) begin
						af_q    <= AF_W'(div_quo);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign clock_select  = cs_q;
	assign compare_value = cv_q;
	assign compare_write = cw_q;
	assign actual_freq   = af_q;

`ifndef NO_ASSERTIONS
	// result strobe only once the controller is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// compare write follows a running clock
	a_cw_cs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (compare_write == (clock_select != CS_STOP)))
		else $error("compare_write inconsistent with clock_select");

	// a zero request stops the timer on the next cycle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && requested_freq == '0) |=> (done && clock_select == CS_STOP))
		else $error("zero request not answered with stop");

	// divider finishes only inside a division state
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVQ || state_q == ST_DIVF))
		else $error("divider finished outside a division");
`endif

endmodule

// File: hw/rtl/tfsc_div.sv
// Restoring divider, one quotient bit per cycle.
module tfsc_div #(
	parameter int W = 22
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    trial;
	logic          fits;

	// shift in next dividend bit and try subtract
	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: bench/timer_frequency_setup_calculator_tb.sv
module timer_frequency_setup_calculator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfsc_pkg::*;

	localparam int unsigned HALF_CLK   = CLOCK_HZ_DEF / 2;
	localparam int unsigned PRESCALE [NUM_PRESC] = '{1, 8, 32, 64, 128, 256, 1024};
	localparam int          RANDOM_REQS = 1100;
	localparam int          STALL_LIMIT = 2000;
	localparam int          SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [CS_W-1:0] cs;
		logic [CV_W-1:0] cv;
		logic            cw;
		logic [AF_W-1:0] af;
	} timer_setup_t;

	// expected timer settings, one per accepted request
	class setup_scoreboard;
		timer_setup_t pending_setups[$];
		int           errors;
		int           checked;
		logic [7:0]   cs_seen;

		function new();
			errors  = 0;
			checked = 0;
			cs_seen = '0;
		endfunction

		function timer_setup_t slowest_setup();
			timer_setup_t s;
			s.cs = CS_SLOWEST;
			s.cv = CV_W'(MAX_DIV - 1);
			s.cw = 1'b1;
			s.af = AF_W'((HALF_CLK / PRESCALE[NUM_PRESC-1]) / MAX_DIV);
			return s;
		endfunction

		function timer_setup_t predict_setup(logic [REQ_W-1:0] freq);
			timer_setup_t s;
			int unsigned  rate;
			int unsigned  q;
			if (freq == 0) begin
				s = '{cs: CS_STOP, cv: '0, cw: 1'b0, af: '0};
				return s;
			end
			if (freq <= SLOW_LIMIT)
				return slowest_setup();
			if (freq >= HALF_CLK) begin
				s = '{cs: CS_FASTEST, cv: '0, cw: 1'b1, af: AF_W'(HALF_CLK)};
				return s;
			end
			// first prescaler whose divisor is at most 256
			for (int k = 0; k < NUM_PRESC; k++) begin
				rate = HALF_CLK / PRESCALE[k];
				q = rate / freq;
				if (q <= MAX_DIV) begin
					if (q == 0)
						q = 1;
					s.cs = CS_W'(k + 1);
					s.cv = CV_W'(q - 1);
					s.cw = 1'b1;
					s.af = AF_W'(rate / q);
					return s;
				end
			end
			return slowest_setup();
		endfunction

		function void note_request(logic [REQ_W-1:0] freq);
			pending_setups.push_back(predict_setup(freq));
		endfunction

		function void check_result(logic [CS_W-1:0] cs, logic [CV_W-1:0] cv, logic cw,
			logic [AF_W-1:0] af);
			timer_setup_t e;
			if (pending_setups.size() == 0) begin
				$error("result with no request outstanding: cs=%0d cv=%0d cw=%0d af=%0d",
					cs, cv, cw, af);
				errors++;
				return;
			end
			e = pending_setups.pop_front();
			checked++;
			cs_seen[cs] = 1'b1;
			if (cs !== e.cs) begin
				$error("clock_select: expected %0d, got %0d", e.cs, cs);
				errors++;
			end
			if (cv !== e.cv) begin
				$error("compare_value: expected %0d, got %0d", e.cv, cv);
				errors++;
			end
			if (cw !== e.cw) begin
				$error("compare_write: expected %0d, got %0d", e.cw, cw);
				errors++;
			end
			if (af !== e.af) begin
				$error("actual_freq: expected %0d, got %0d", e.af, af);
				errors++;
			end
		endfunction

		function int pending();
			return pending_setups.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [REQ_W-1:0] requested_freq = '0;
	logic             busy;
	logic             done;
	logic [CS_W-1:0]  clock_select;
	logic [CV_W-1:0]  compare_value;
	logic             compare_write;
	logic [AF_W-1:0]  actual_freq;

	setup_scoreboard sb = new();
	int              idle_cycles = 0;

	timer_frequency_setup_calculator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.requested_freq(requested_freq),
		.busy          (busy),
		.done          (done),
		.clock_select  (clock_select),
		.compare_value (compare_value),
		.compare_write (compare_write),
		.actual_freq   (actual_freq)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitor: record accepted requests, check each result strobe
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(requested_freq);
			if (done)
				sb.check_result(clock_select, compare_value, compare_write, actual_freq);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("** timer_frequency_setup_calculator: FAILED **");
				$finish;
			end
		end
	end

	// present one request and hold it until the block takes it
	task automatic send(logic [REQ_W-1:0] freq);
		start <= 1'b1;
		requested_freq <= freq;
		do
			@(posedge clk);
		while (busy);
	endtask

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic idle_after(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sample at the falling edge so the monitor has already run
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [REQ_W-1:0] rand_request();
		int          b;
		int unsigned rate;
		case ($urandom_range(0, 9))
			0: return REQ_W'($urandom_range(0, 20));
			1: return $urandom();
			2: return REQ_W'($urandom_range(HALF_CLK + 3, HALF_CLK - 3));
			3: begin
				// near the divisor limit of some prescaler
				rate = HALF_CLK / PRESCALE[$urandom_range(0, NUM_PRESC - 1)];
				return REQ_W'(rate / $urandom_range(250, 260) + $urandom_range(0, 2));
			end
			default: begin
				b = $urandom_range(4, 23);
				return REQ_W'($urandom_range((1 << b) - 1, 1 << (b - 1)));
			end
		endcase
	endfunction

	logic [REQ_W-1:0] directed_reqs[$] = '{
		32'd0, 32'd1, 32'd15, 32'd16, 32'd60, 32'd61, 32'd122, 32'd244,
		32'd488, 32'd1953, 32'd1954, 32'd15564, 32'd15625, 32'd15626,
		32'd3999999, 32'd4000000, 32'd4000001, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h5555_5555, 32'hAAAA_AAAA, 32'd1000, 32'd440
	};

	initial begin
		bit quiet;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stop, slowest, fastest, divisor of 256, prescaler edges
		foreach (directed_reqs[i]) begin
			send(directed_reqs[i]);
			idle_after(pick_gap());
		end
		drain();

		// random requests
		quiet = 1'b0;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i % 250 == 125)
				drain();
			send(rand_request());
			idle_after(quiet ? 0 : pick_gap());
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Checked %0d setup transactions, stop/slow/fast/divisor edges included.",
			sb.checked);
		$display("Clock-select codes seen (bit per code): %b", sb.cs_seen);
		if (sb.errors == 0)
			$display("** timer_frequency_setup_calculator: PASSED **");
		else
			$display("** timer_frequency_setup_calculator: FAILED **");
		$finish;
	end

endmodule
